### rtl/pisq_pkg.sv
// ----------------------------------------------------------------------------
// pisq_pkg
// Types and constants shared by the PWM input stability qualifier and its
// port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pisq_pkg;

    // Field widths
    localparam int unsigned FREQ_W  = 16;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_DEV_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_DEV_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILURES_ALLOWED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUCCESSES_NEEDED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DELAY_TICKS = 3'd4;

    // Configuration reset values
    localparam logic [FREQ_W-1:0]  RST_FREQ_DEV_LIMIT    = 16'd10;
    localparam logic [DUTY_W-1:0]  RST_DUTY_DEV_LIMIT    = 10'd10;
    localparam logic [COUNT_W-1:0] RST_FAILURES_ALLOWED  = 8'd3;
    localparam logic [COUNT_W-1:0] RST_SUCCESSES_NEEDED  = 8'd3;
    localparam logic [TICKS_W-1:0] RST_CLEAR_DELAY_TICKS = 16'd1000;

    // Saturation value of the qualification counters
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One input item per tick
    typedef struct packed {
        logic              new_measurement;
        logic [FREQ_W-1:0] measured_freq;
        logic [DUTY_W-1:0] measured_duty;
        logic              pulldown_released;
    } in_item_t;

    // One result item per tick
    typedef struct packed {
        logic [FREQ_W-1:0] qualified_freq;
        logic [DUTY_W-1:0] qualified_duty;
        logic              no_signal;
        logic              latched_now;
    } out_item_t;

endpackage

`default_nettype wire

### rtl/pwm_input_stability_qualifier_core.sv
// ----------------------------------------------------------------------------
// pwm_input_stability_qualifier_core
// Qualifies PWM frequency/duty measurements: a run of stable measurements is
// latched as the qualified output, released-pulldown ticks without
// measurements raise a no-signal flag after a configurable timeout.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Moves
//  input     s_valid / s_ready / s_data    one tick item (in_item_t)
//  result    m_valid / m_ready / m_data    one result item (out_item_t)
//  config    cfg_wr_en / cfg_index / cfg_wdata   register write, no wait
//
//  While s_ready is high, one item per cycle: the state is updated in the
//  cycle an item is accepted and its result sits in the output register
//  from the next cycle. s_ready is high while the output register is empty
//  or being taken, so a stalled result holds back only one further item.
//  aresetn (synchronous) clears state and result valid, and loads the
//  register defaults. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_input_stability_qualifier_core
    import pisq_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    // Configuration registers
    logic [FREQ_W-1:0]  freq_limit_reg;
    logic [DUTY_W-1:0]  duty_limit_reg;
    logic [COUNT_W-1:0] fail_allowed_reg;
    logic [COUNT_W-1:0] succ_needed_reg;
    logic [TICKS_W-1:0] clear_delay_reg;

    // Qualifier state
    logic [FREQ_W-1:0]  prev_freq_reg, prev_freq_next;
    logic [DUTY_W-1:0]  prev_duty_reg, prev_duty_next;
    logic [COUNT_W-1:0] succ_cnt_reg, succ_cnt_next;
    logic [COUNT_W-1:0] fail_cnt_reg, fail_cnt_next;
    logic [TICKS_W-1:0] idle_ticks_reg, idle_ticks_next;
    logic [FREQ_W-1:0]  held_freq_reg, held_freq_next;
    logic [DUTY_W-1:0]  held_duty_reg, held_duty_next;
    logic               lost_reg, lost_next;

    // Result register
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    // Datapath intermediates
    logic               accept;
    logic [FREQ_W-1:0]  freq_diff;
    logic [DUTY_W-1:0]  duty_diff;
    logic               stable;
    logic [COUNT_W-1:0] succ_inc, fail_inc;
    logic [COUNT_W-1:0] succ_a, fail_a, succ_b, fail_b;
    logic               fail_clear, latch;
    logic [TICKS_W:0]   idle_inc;
    logic               expire;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_limit_reg   <= RST_FREQ_DEV_LIMIT;
            duty_limit_reg   <= RST_DUTY_DEV_LIMIT;
            fail_allowed_reg <= RST_FAILURES_ALLOWED;
            succ_needed_reg  <= RST_SUCCESSES_NEEDED;
            clear_delay_reg  <= RST_CLEAR_DELAY_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FREQ_DEV_LIMIT:    freq_limit_reg   <= cfg_wdata[FREQ_W-1:0];
                CFG_DUTY_DEV_LIMIT:    duty_limit_reg   <= cfg_wdata[DUTY_W-1:0];
                CFG_FAILURES_ALLOWED:  fail_allowed_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_SUCCESSES_NEEDED:  succ_needed_reg  <= cfg_wdata[COUNT_W-1:0];
                CFG_CLEAR_DELAY_TICKS: clear_delay_reg  <= cfg_wdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Step sizes against the previous measurement
    always_comb begin
        freq_diff = (s_data.measured_freq > prev_freq_reg)
                  ? s_data.measured_freq - prev_freq_reg
                  : prev_freq_reg - s_data.measured_freq;
        duty_diff = (s_data.measured_duty > prev_duty_reg)
                  ? s_data.measured_duty - prev_duty_reg
                  : prev_duty_reg - s_data.measured_duty;
        stable    = (freq_diff < freq_limit_reg) && (duty_diff < duty_limit_reg);
    end

    // Saturating counts, failure clear first, then the latch check
    always_comb begin
        succ_inc   = (succ_cnt_reg == COUNT_MAX) ? COUNT_MAX : succ_cnt_reg + 1'b1;
        fail_inc   = (fail_cnt_reg == COUNT_MAX) ? COUNT_MAX : fail_cnt_reg + 1'b1;
        succ_a     = stable ? succ_inc : succ_cnt_reg;
        fail_a     = stable ? fail_cnt_reg : fail_inc;
        fail_clear = (fail_a >= fail_allowed_reg);
        succ_b     = fail_clear ? '0 : succ_a;
        fail_b     = fail_clear ? '0 : fail_a;
        latch      = (succ_b >= succ_needed_reg);
    end

    // Idle timeout, compared one bit wider so the full delay range expires
    always_comb begin
        idle_inc = {1'b0, idle_ticks_reg} + 1'b1;
        expire   = (idle_inc > {1'b0, clear_delay_reg});
    end

    // Next state for one accepted item
    always_comb begin
        prev_freq_next  = prev_freq_reg;
        prev_duty_next  = prev_duty_reg;
        succ_cnt_next   = succ_cnt_reg;
        fail_cnt_next   = fail_cnt_reg;
        idle_ticks_next = idle_ticks_reg;
        held_freq_next  = held_freq_reg;
        held_duty_next  = held_duty_reg;
        lost_next       = lost_reg;

        if (accept) begin
            if (s_data.new_measurement) begin
                prev_freq_next  = s_data.measured_freq;
                prev_duty_next  = s_data.measured_duty;
                succ_cnt_next   = latch ? '0 : succ_b;
                fail_cnt_next   = latch ? '0 : fail_b;
                idle_ticks_next = '0;
                if (latch) begin
                    held_freq_next = s_data.measured_freq;
                    held_duty_next = s_data.measured_duty;
                    lost_next      = 1'b0;
                end
            end else if (s_data.pulldown_released) begin
                if (expire) begin
                    idle_ticks_next = clear_delay_reg;
                    lost_next       = 1'b1;
                end else begin
                    idle_ticks_next = idle_inc[TICKS_W-1:0];
                end
            end
        end
    end

    // Result register load
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next               = 1'b1;
            m_data_next.qualified_freq = held_freq_next;
            m_data_next.qualified_duty = held_duty_next;
            m_data_next.no_signal      = lost_next;
            m_data_next.latched_now    = s_data.new_measurement && latch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_freq_reg  <= '0;
            prev_duty_reg  <= '0;
            succ_cnt_reg   <= '0;
            fail_cnt_reg   <= '0;
            idle_ticks_reg <= '0;
            held_freq_reg  <= '0;
            held_duty_reg  <= '0;
            lost_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            prev_freq_reg  <= prev_freq_next;
            prev_duty_reg  <= prev_duty_next;
            succ_cnt_reg   <= succ_cnt_next;
            fail_cnt_reg   <= fail_cnt_next;
            idle_ticks_reg <= idle_ticks_next;
            held_freq_reg  <= held_freq_next;
            held_duty_reg  <= held_duty_next;
            lost_reg       <= lost_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

### rtl/pisq_port_checker.sv
// ----------------------------------------------------------------------------
// pisq_port_checker
// Port-level checks on the PWM input stability qualifier, bound to the
// qualifier core module.
// ----------------------------------------------------------------------------
`default_nettype none

module pisq_port_checker
    import pisq_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data
);

    // A stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Nothing is offered straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An empty output register always takes an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A latch clears the no-signal flag
    a_latch_clears_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.latched_now |-> !m_data.no_signal)
        else $error("no-signal set on a latching item");

    // A tick without measurement never latches
    a_no_meas_no_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.new_measurement |=> !m_data.latched_now)
        else $error("latch without measurement");

endmodule

bind pwm_input_stability_qualifier_core pisq_port_checker u_pisq_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

### tb/tb_pwm_input_stability_qualifier_core.sv
// ----------------------------------------------------------------------------
// tb_pwm_input_stability_qualifier_core
// Self-checking bench for the PWM input stability qualifier. Tick items go in
// over a valid/ready channel with random gaps. Each accepted tick is run
// through a behavioural model of the qualifier kept in a scoreboard class.
// Every result item is compared field by field with the oldest prediction.
// The stimulus is a directed pass over the corner cases followed by
// randomised phases, each with its own register settings.
// ----------------------------------------------------------------------------
`default_nettype none

package tb_pisq_sb_pkg;

    import pisq_pkg::*;

    // Behavioural model of the qualifier plus the queue of predicted results
    class qualifier_scoreboard;

        // register copies
        logic [FREQ_W-1:0]  freq_lim;
        logic [DUTY_W-1:0]  duty_lim;
        logic [COUNT_W-1:0] fail_allowed;
        logic [COUNT_W-1:0] succ_needed;
        logic [TICKS_W-1:0] clear_delay;

        // qualifier state
        logic [FREQ_W-1:0]  prev_freq;
        logic [DUTY_W-1:0]  prev_duty;
        logic [COUNT_W-1:0] succ_cnt;
        logic [COUNT_W-1:0] fail_cnt;
        logic [TICKS_W-1:0] idle_ticks;
        logic [FREQ_W-1:0]  held_freq;
        logic [DUTY_W-1:0]  held_duty;
        logic               lost;

        out_item_t expected_quals[$];
        int        errors;

        function new();
            freq_lim     = RST_FREQ_DEV_LIMIT;
            duty_lim     = RST_DUTY_DEV_LIMIT;
            fail_allowed = RST_FAILURES_ALLOWED;
            succ_needed  = RST_SUCCESSES_NEEDED;
            clear_delay  = RST_CLEAR_DELAY_TICKS;
            prev_freq    = '0;
            prev_duty    = '0;
            succ_cnt     = '0;
            fail_cnt     = '0;
            idle_ticks   = '0;
            held_freq    = '0;
            held_duty    = '0;
            lost         = 1'b0;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FREQ_DEV_LIMIT:    freq_lim     = val[FREQ_W-1:0];
                CFG_DUTY_DEV_LIMIT:    duty_lim     = val[DUTY_W-1:0];
                CFG_FAILURES_ALLOWED:  fail_allowed = val[COUNT_W-1:0];
                CFG_SUCCESSES_NEEDED:  succ_needed  = val[COUNT_W-1:0];
                CFG_CLEAR_DELAY_TICKS: clear_delay  = val[TICKS_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_quals.size();
        endfunction

        // Advance the model by one accepted tick and queue its result
        function void note_tick(in_item_t t);
            out_item_t          r;
            logic [FREQ_W-1:0]  df;
            logic [DUTY_W-1:0]  dd;
            logic [TICKS_W:0]   nxt;
            r.latched_now = 1'b0;
            if (t.new_measurement) begin
                df = (t.measured_freq > prev_freq) ? t.measured_freq - prev_freq
                                                   : prev_freq - t.measured_freq;
                dd = (t.measured_duty > prev_duty) ? t.measured_duty - prev_duty
                                                   : prev_duty - t.measured_duty;
                // stable only if both steps lie strictly under their limits
                if (df < freq_lim && dd < duty_lim) begin
                    if (succ_cnt != COUNT_MAX) succ_cnt++;
                end else begin
                    if (fail_cnt != COUNT_MAX) fail_cnt++;
                end
                prev_freq = t.measured_freq;
                prev_duty = t.measured_duty;
                // failure check first; the success check sees its outcome
                if (fail_cnt >= fail_allowed) begin
                    succ_cnt = '0;
                    fail_cnt = '0;
                end
                if (succ_cnt >= succ_needed) begin
                    succ_cnt      = '0;
                    fail_cnt      = '0;
                    held_freq     = prev_freq;
                    held_duty     = prev_duty;
                    lost          = 1'b0;
                    r.latched_now = 1'b1;
                end
                idle_ticks = '0;
            end else if (t.pulldown_released) begin
                // 17-bit compare so a delay of all ones still expires
                nxt = {1'b0, idle_ticks} + 1'b1;
                if (nxt > {1'b0, clear_delay}) begin
                    idle_ticks = clear_delay;
                    lost       = 1'b1;
                end else begin
                    idle_ticks = nxt[TICKS_W-1:0];
                end
            end
            r.qualified_freq = held_freq;
            r.qualified_duty = held_duty;
            r.no_signal      = lost;
            expected_quals.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, exp_v, act_v);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (expected_quals.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            exp_r = expected_quals.pop_front();
            compare_field("qualified_freq", 32'(exp_r.qualified_freq),
                          32'(got.qualified_freq));
            compare_field("qualified_duty", 32'(exp_r.qualified_duty),
                          32'(got.qualified_duty));
            compare_field("no_signal", 32'(exp_r.no_signal), 32'(got.no_signal));
            compare_field("latched_now", 32'(exp_r.latched_now), 32'(got.latched_now));
        endfunction

    endclass

endpackage

module tb_pwm_input_stability_qualifier_core;

    timeunit 1ns;
    timeprecision 1ps;

    import pisq_pkg::*;
    import tb_pisq_sb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    qualifier_scoreboard sb = new();

    bit quiet      = 1'b0;   // no idling on either side while set
    int last_freq  = 0;
    int last_duty  = 0;
    int stall_cnt  = 0;

    pwm_input_stability_qualifier_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #1 aclk = ~aclk;

    // Mostly short gaps, a few long ones, none in quiet stretches
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t mk_meas(int f, int d);
        in_item_t t;
        t.new_measurement   = 1'b1;
        t.measured_freq     = FREQ_W'(f);
        t.measured_duty     = DUTY_W'(d);
        t.pulldown_released = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic in_item_t mk_idle(logic rel);
        in_item_t t;
        t.new_measurement   = 1'b0;
        t.measured_freq     = FREQ_W'($urandom);
        t.measured_duty     = DUTY_W'($urandom_range(0, 1000));
        t.pulldown_released = rel;
        return t;
    endfunction

    // Mostly small steps around the last measurement so runs of successes
    // build up; the rest is wide noise, extremes and idle ticks
    function automatic in_item_t random_tick();
        in_item_t t;
        int r, f, d, fl, dl, fstep, dstep;
        r  = $urandom_range(0, 99);
        fl = int'(sb.freq_lim);
        dl = int'(sb.duty_lim);
        t  = mk_meas($urandom_range(0, 65535), $urandom_range(0, 1000));
        if (r < 62) begin
            fstep = (fl == 0) ? 0 : $urandom_range(0, (fl > 40) ? 39 : fl - 1);
            dstep = (dl == 0) ? 0 : $urandom_range(0, (dl > 40) ? 39 : dl - 1);
            if ($urandom_range(0, 9) == 0) fstep = fstep + $urandom_range(0, 3);
            f = last_freq + (($urandom_range(0, 1) == 1) ? fstep : -fstep);
            d = last_duty + (($urandom_range(0, 1) == 1) ? dstep : -dstep);
            if (f < 0) f = 0;
            if (f > 65535) f = 65535;
            if (d < 0) d = 0;
            if (d > 1000) d = 1000;
            t.measured_freq = FREQ_W'(f);
            t.measured_duty = DUTY_W'(d);
        end else if (r < 75) begin
            // wide noise: values already random
        end else if (r < 80) begin
            t.measured_freq = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            t.measured_duty = ($urandom_range(0, 1) == 1) ? 10'd1000 : 10'd0;
        end else begin
            t = mk_idle($urandom_range(0, 3) != 0);
        end
        if (t.new_measurement) begin
            last_freq = int'(t.measured_freq);
            last_duty = int'(t.measured_duty);
        end
        return t;
    endfunction

    // Offer one item, hold it until taken, then maybe idle
    task automatic send_tick(input in_item_t t);
        int gap;
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the sender off until every predicted result has arrived
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_config(input int fl, input int dl, input int fa,
                               input int sn, input int cd);
        settle();
        write_reg(CFG_FREQ_DEV_LIMIT, CFG_DATA_W'(fl));
        write_reg(CFG_DUTY_DEV_LIMIT, CFG_DATA_W'(dl));
        write_reg(CFG_FAILURES_ALLOWED, CFG_DATA_W'(fa));
        write_reg(CFG_SUCCESSES_NEEDED, CFG_DATA_W'(sn));
        write_reg(CFG_CLEAR_DELAY_TICKS, CFG_DATA_W'(cd));
    endtask

    // Result side: ready in random bursts with short and long stalls
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (!quiet) begin
                m_ready <= 1'b0;
                if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 3)) @(posedge aclk);
                else repeat ($urandom_range(8, 40)) @(posedge aclk);
            end
        end
    end

    // Monitor: check results, then note accepted ticks
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_tick(s_data);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int ph, n_items, fl, dl, fa, sn, cd;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults: first measurement against zero, a latch on the third
        send_tick(mk_meas(5, 3));
        send_tick(mk_meas(8, 6));
        send_tick(mk_meas(12, 9));
        // full-scale steps fail, pull-down held changes nothing
        send_tick(mk_meas(65535, 1000));
        send_tick(mk_meas(0, 0));
        send_tick(mk_idle(1'b0));
        send_tick(mk_idle(1'b1));
        send_tick(mk_meas(0, 0));
        send_tick(mk_meas(65535, 1000));

        // Zero limits and zero delay: immediate no-signal, then failure
        // clear followed by a latch on a zero success threshold
        load_config(0, 0, 1, 0, 0);
        send_tick(mk_idle(1'b1));
        send_tick(mk_idle(1'b1));
        send_tick(mk_meas(100, 500));
        send_tick(mk_idle(1'b1));
        send_tick(mk_meas(65535, 0));

        // Widest limits, zero failures allowed clears on every measurement;
        // the delay expires on the idle tick after its full run
        load_config(65535, 1000, 0, 2, 200);
        send_tick(mk_meas(1, 1));
        send_tick(mk_meas(2, 2));
        quiet = 1'b1;
        for (int k = 0; k < 201; k++) send_tick(mk_idle(1'b1));
        quiet = 1'b0;
        send_tick(mk_idle(1'b1));
        send_tick(mk_meas(300, 400));

        // Randomised phases with their own register settings
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin fl = 65535; dl = 1000; fa = 255; sn = 255; cd = 0; end
                1: begin fl = 0; dl = 0; fa = 1; sn = 1; cd = 65535; end
                default: begin
                    case ($urandom_range(0, 2))
                        0: fl = 1;
                        1: fl = $urandom_range(1, 200);
                        default: fl = 65535;
                    endcase
                    case ($urandom_range(0, 2))
                        0: dl = 1;
                        1: dl = $urandom_range(1, 100);
                        default: dl = 1000;
                    endcase
                    fa = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 6);
                    sn = ($urandom_range(0, 6) == 0) ? 255 : $urandom_range(1, 6);
                    cd = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 2000)
                                                     : $urandom_range(0, 30);
                end
            endcase
            load_config(fl, dl, fa, sn, cd);
            n_items = (ph == 0) ? 250 : 170;
            for (int i = 0; i < n_items; i++) begin
                quiet = (ph % 3 == 1) && (i < 40);
                if ($urandom_range(0, 99) == 0) settle();
                send_tick(random_tick());
            end
            quiet = 1'b0;
        end

        // Drain and finish
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
